// File: hdl/simpson_three_eighths_integrator_macros.svh
// Assertion macros shared by the integrator RTL.
`ifndef SIMPSON_THREE_EIGHTHS_INTEGRATOR_MACROS_SVH
`define SIMPSON_THREE_EIGHTHS_INTEGRATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIMP38_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SIMP38_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/simp38_pkg.sv
// Types, widths and codes shared by the Simpson 3/8 integrator modules.
package simp38_pkg;

    localparam int unsigned LIMIT_W   = 24;
    localparam int unsigned COUNT_W   = 10;
    localparam int unsigned AREA_W    = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_TUSER_W = 2;

    localparam int unsigned MAX_INTERVALS = 1023;

    // shared divider: 64-bit dividend, 47-bit divisor, 24 or 38 quotient bits
    localparam int unsigned DIVD_W    = 64;
    localparam int unsigned DVSR_W    = 47;
    localparam int unsigned QUO_W     = 38;
    localparam int unsigned SHORT_QUO = 24;
    localparam int unsigned DCNT_W    = $clog2(QUO_W + 1);

    // shared multiplier
    localparam int unsigned MUL_A_W = 26;
    localparam int unsigned MUL_B_W = 24;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    localparam int unsigned ACC_W   = 37;
    localparam int unsigned MAG_W   = 36;
    localparam int unsigned MAG_LO  = 18;
    localparam int unsigned XACC_W  = 61;
    localparam int unsigned OFFR_W  = COUNT_W + 2;
    localparam int unsigned F_SHIFT = 40;
    localparam int unsigned ONE_SQ  = 32;
    localparam int unsigned HALF_SH = 22;
    localparam int unsigned AREA_SH = 23;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_ORDER = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP_WAIT,
        ST_X,
        ST_SQ,
        ST_FSTART,
        ST_FDIV_WAIT,
        ST_ACC,
        ST_FIN_LO,
        ST_FIN_HI,
        ST_FIN_SUM,
        ST_ASTART,
        ST_AREA_WAIT,
        ST_PUBLISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_STEP,
        OP_X,
        OP_SQ,
        OP_ACC,
        OP_FIN_LO,
        OP_FIN_HI,
        OP_FIN_SUM,
        OP_PUBLISH
    } dp_op_t;

    typedef enum logic [1:0] {
        DIV_STEP,
        DIV_SAMPLE,
        DIV_AREA
    } div_sel_t;

    typedef struct packed {
        dp_op_t   op;
        logic     div_start;
        div_sel_t div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_sample;
        logic error;
    } dp_stat_t;

endpackage

// File: hdl/simp38_div.sv
// Shared restoring divider, one quotient bit per cycle.
`include "simpson_three_eighths_integrator_macros.svh"

module simp38_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic                             long_mode,
    input  logic [simp38_pkg::DIVD_W-1:0]    dividend,
    input  logic [simp38_pkg::DVSR_W-1:0]    divisor,
    output logic                             done,
    output logic [simp38_pkg::QUO_W-1:0]     quotient,
    output logic [simp38_pkg::DVSR_W-1:0]    remainder
);

    localparam int unsigned DW = simp38_pkg::DIVD_W;
    localparam int unsigned VW = simp38_pkg::DVSR_W;
    localparam int unsigned QW = simp38_pkg::QUO_W;
    localparam int unsigned SQ = simp38_pkg::SHORT_QUO;
    localparam int unsigned CW = simp38_pkg::DCNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [QW-1:0] sh_reg, sh_next;
    logic [VW-1:0] dvsr_reg, dvsr_next;

    logic [VW:0]   trial;
    logic [VW+1:0] diff;

    always_comb begin
        trial = {rem_reg, sh_reg[QW-1]};
        diff  = {1'b0, trial} - {2'b00, dvsr_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dvsr_next = dvsr_reg;
        if (start) begin
            busy_next = 1'b1;
            dvsr_next = divisor;
            if (long_mode) begin
                cnt_next = CW'(QW);
                rem_next = VW'(dividend[DW-1:QW]);
                sh_next  = dividend[QW-1:0];
            end else begin
                cnt_next = CW'(SQ);
                rem_next = VW'(dividend[DW-1:SQ]);
                sh_next  = {dividend[SQ-1:0], (QW-SQ)'(0)};
            end
        end else if (busy_reg) begin
            // keep the trial difference unless it borrowed
            if (diff[VW+1]) begin
                rem_next = trial[VW-1:0];
                sh_next  = {sh_reg[QW-2:0], 1'b0};
            end else begin
                rem_next = diff[VW-1:0];
                sh_next  = {sh_reg[QW-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        dvsr_reg <= dvsr_next;
    end

    assign done      = done_reg;
    assign quotient  = sh_reg;
    assign remainder = rem_reg;

    `SIMP38_ASSERT_SAME(a_div_start_idle, aclk, aresetn, start, !busy_reg, "divider restarted while busy")

endmodule

// File: hdl/simp38_dp.sv
// Datapath: sample generation, f(x) evaluation, weighted sum and final scaling.
`include "simpson_three_eighths_integrator_macros.svh"

module simp38_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [simp38_pkg::S_TDATA_W-1:0]    s_tdata,
    input  simp38_pkg::dp_cmd_t                 cmd,
    output simp38_pkg::dp_stat_t                stat,
    output logic [simp38_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [simp38_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int unsigned LW  = simp38_pkg::LIMIT_W;
    localparam int unsigned NW  = simp38_pkg::COUNT_W;
    localparam int unsigned DW  = simp38_pkg::DIVD_W;
    localparam int unsigned VW  = simp38_pkg::DVSR_W;
    localparam int unsigned QW  = simp38_pkg::QUO_W;
    localparam int unsigned SQ  = simp38_pkg::SHORT_QUO;
    localparam int unsigned AW  = simp38_pkg::MUL_A_W;
    localparam int unsigned BW  = simp38_pkg::MUL_B_W;
    localparam int unsigned PW  = simp38_pkg::PROD_W;
    localparam int unsigned CW  = simp38_pkg::ACC_W;
    localparam int unsigned MW  = simp38_pkg::MAG_W;
    localparam int unsigned ML  = simp38_pkg::MAG_LO;
    localparam int unsigned XW  = simp38_pkg::XACC_W;
    localparam int unsigned RW  = simp38_pkg::OFFR_W;
    localparam int unsigned OW  = simp38_pkg::AREA_W;
    localparam int unsigned YW  = SQ + 2;

    localparam logic [QW-1:0] POS_MAX = QW'((64'd1 << (OW - 1)) - 64'd1);
    localparam logic [QW-1:0] NEG_MAX = QW'(64'd1 << (OW - 1));

    // input word fields
    logic signed [LW-1:0] in_lower;
    logic signed [LW-1:0] in_upper;
    logic [NW-1:0]        in_count;
    logic [NW-1:0]        n_eff;
    logic [LW:0]          in_span;
    simp38_pkg::status_t  in_status;

    assign in_lower = s_tdata[LW-1:0];
    assign in_upper = s_tdata[2*LW-1:LW];
    assign in_count = s_tdata[2*LW+NW-1:2*LW];

    always_comb begin
        n_eff = (32'(in_count) > simp38_pkg::MAX_INTERVALS)
              ? NW'(simp38_pkg::MAX_INTERVALS) : in_count;
        in_span = {in_upper[LW-1], in_upper} - {in_lower[LW-1], in_lower};
        if (in_upper < in_lower) begin
            in_status = simp38_pkg::STATUS_ORDER;
        end else if (in_count == '0) begin
            in_status = simp38_pkg::STATUS_EMPTY;
        end else begin
            in_status = simp38_pkg::STATUS_OK;
        end
    end

    // working registers
    logic signed [LW-1:0] a_reg;
    logic [LW-1:0]        d_reg;
    logic [NW-1:0]        n_reg;
    simp38_pkg::status_t  status_reg;
    logic [LW-1:0]        qd_reg;
    logic [NW:0]          rd_reg;
    logic [LW-1:0]        off_q_reg;
    logic [RW-1:0]        off_r_reg;
    logic [NW-1:0]        i_reg;
    logic [1:0]           mod3_reg;
    logic [LW-1:0]        ax_reg;
    logic                 neg_reg;
    logic [PW-1:0]        prod_reg;
    logic signed [CW-1:0] acc_reg;
    logic [XW-1:0]        xacc_reg;
    logic [OW-1:0]        area_out_reg;
    simp38_pkg::status_t  status_out_reg;

    // divider
    logic          div_done;
    logic [QW-1:0] div_quo;
    logic [VW-1:0] div_rem;
    logic [DW-1:0] div_dividend;
    logic [VW-1:0] div_divisor;
    logic          div_long;
    logic [VW-1:0] den;

    assign den = (VW'(1) << simp38_pkg::ONE_SQ) + VW'(prod_reg);

    always_comb begin
        div_long     = 1'b0;
        div_dividend = DW'(d_reg);
        div_divisor  = VW'(n_reg);
        case (cmd.div_sel)
            simp38_pkg::DIV_SAMPLE: begin
                // |x| * 2^40 plus half the denominator for round to nearest
                div_dividend = {ax_reg, (DW-LW)'(0)} + DW'(den[VW-1:1]);
                div_divisor  = den;
            end
            simp38_pkg::DIV_AREA: begin
                div_long     = 1'b1;
                div_dividend = DW'(xacc_reg[XW-1:simp38_pkg::AREA_SH]);
                div_divisor  = VW'(n_reg);
            end
            default: begin
                div_dividend = DW'(d_reg);
                div_divisor  = VW'(n_reg);
            end
        endcase
    end

    simp38_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .long_mode (div_long),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // sample point x = a + offset
    logic [LW:0]   x_wide;
    logic [LW-1:0] x_val;

    always_comb begin
        x_wide = {a_reg[LW-1], a_reg} + {1'b0, off_q_reg};
        x_val  = x_wide[LW-1:0];
    end

    // magnitude of the weighted sum and 3*d
    logic [CW-1:0] acc_abs;
    logic [MW-1:0] mag;
    logic [AW-1:0] a3;

    always_comb begin
        acc_abs = acc_reg[CW-1] ? CW'(-acc_reg) : CW'(acc_reg);
        mag     = acc_abs[MW-1:0];
        a3      = {1'b0, d_reg, 1'b0} + AW'(d_reg);
    end

    // shared multiplier
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [PW-1:0] mul_p;

    always_comb begin
        mul_a = a3;
        mul_b = BW'(mag[ML-1:0]);
        case (cmd.op)
            simp38_pkg::OP_SQ: begin
                mul_a = AW'(ax_reg);
                mul_b = ax_reg;
            end
            simp38_pkg::OP_FIN_HI: begin
                mul_b = BW'(mag[MW-1:ML]);
            end
            default: begin
                mul_b = BW'(mag[ML-1:0]);
            end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // weight and weighted sample
    logic [1:0]    weight;
    logic [NW:0]   i_plus2;
    logic [SQ-1:0] y;
    logic [YW-1:0] wy;
    logic [CW-1:0] wy_ext;

    always_comb begin
        i_plus2 = {1'b0, i_reg} + (NW+1)'(2);
        y       = div_quo[SQ-1:0];
        if (i_reg == '0 || i_reg == n_reg) begin
            weight = 2'd1;
        end else if (mod3_reg != 2'd0) begin
            weight = 2'd3;
        end else if (i_plus2 < {1'b0, n_reg}) begin
            weight = 2'd2;
        end else begin
            weight = 2'd0;
        end
        case (weight)
            2'd1:    wy = YW'(y);
            2'd2:    wy = {1'b0, y, 1'b0};
            2'd3:    wy = {1'b0, y, 1'b0} + YW'(y);
            default: wy = '0;
        endcase
        wy_ext = CW'(wy);
    end

    // offset step: quotient and remainder of (2*i*d + n) / 2n
    logic [RW-1:0] r_sum;
    logic [RW-1:0] two_n;

    always_comb begin
        r_sum = off_r_reg + RW'(rd_reg);
        two_n = {1'b0, n_reg, 1'b0};
    end

    // rounded, saturated area
    logic [QW-1:0] neg_q;
    logic [OW-1:0] area_sat;

    always_comb begin
        neg_q = ~div_quo + QW'(1);
        if (acc_reg[CW-1]) begin
            area_sat = (div_quo > NEG_MAX) ? OW'(NEG_MAX) : neg_q[OW-1:0];
        end else begin
            area_sat = (div_quo > POS_MAX) ? OW'(POS_MAX) : div_quo[OW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            simp38_pkg::OP_LOAD: begin
                a_reg      <= in_lower;
                d_reg      <= in_span[LW-1:0];
                n_reg      <= n_eff;
                status_reg <= in_status;
                i_reg      <= '0;
                mod3_reg   <= 2'd0;
                acc_reg    <= '0;
                off_q_reg  <= '0;
                off_r_reg  <= RW'(n_eff);
            end
            simp38_pkg::OP_STEP: begin
                qd_reg <= div_quo[LW-1:0];
                rd_reg <= {div_rem[NW-1:0], 1'b0};
            end
            simp38_pkg::OP_X: begin
                neg_reg <= x_val[LW-1];
                ax_reg  <= x_val[LW-1] ? (~x_val + LW'(1)) : x_val;
            end
            simp38_pkg::OP_SQ: begin
                prod_reg <= mul_p;
            end
            simp38_pkg::OP_ACC: begin
                acc_reg  <= neg_reg ? (acc_reg - $signed(wy_ext))
                                    : (acc_reg + $signed(wy_ext));
                i_reg    <= i_reg + NW'(1);
                mod3_reg <= (mod3_reg == 2'd2) ? 2'd0 : (mod3_reg + 2'd1);
                if (r_sum >= two_n) begin
                    off_r_reg <= r_sum - two_n;
                    off_q_reg <= off_q_reg + qd_reg + LW'(1);
                end else begin
                    off_r_reg <= r_sum;
                    off_q_reg <= off_q_reg + qd_reg;
                end
            end
            simp38_pkg::OP_FIN_LO: begin
                prod_reg <= mul_p;
            end
            simp38_pkg::OP_FIN_HI: begin
                // add n * 2^22 so the later floor rounds half away from zero
                xacc_reg <= XW'(prod_reg) + (XW'(n_reg) << simp38_pkg::HALF_SH);
                prod_reg <= mul_p;
            end
            simp38_pkg::OP_FIN_SUM: begin
                xacc_reg <= xacc_reg + (XW'(prod_reg) << ML);
            end
            simp38_pkg::OP_PUBLISH: begin
                area_out_reg   <= (status_reg != simp38_pkg::STATUS_OK) ? '0 : area_sat;
                status_out_reg <= status_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        stat.div_done    = div_done;
        stat.last_sample = (i_reg == n_reg);
        stat.error       = (status_reg != simp38_pkg::STATUS_OK);
    end

    assign m_tdata = area_out_reg;
    assign m_tuser = status_out_reg;

    `SIMP38_ASSERT_NEXT(a_dp_error_zero, aclk, aresetn, cmd.op == simp38_pkg::OP_PUBLISH && status_reg != simp38_pkg::STATUS_OK, area_out_reg == '0, "rejected request produced nonzero area")

endmodule

// File: hdl/simp38_ctrl.sv
// Controller: sequences load, per-sample steps, final scaling and output hand-off.
`include "simpson_three_eighths_integrator_macros.svh"

module simp38_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  simp38_pkg::dp_stat_t  stat,
    output simp38_pkg::dp_cmd_t   cmd
);

    simp38_pkg::state_t state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == simp38_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            simp38_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = simp38_pkg::ST_CHECK;
            end
            simp38_pkg::ST_CHECK: begin
                state_next = stat.error ? simp38_pkg::ST_PUBLISH : simp38_pkg::ST_STEP_WAIT;
            end
            simp38_pkg::ST_STEP_WAIT: begin
                if (stat.div_done) state_next = simp38_pkg::ST_X;
            end
            simp38_pkg::ST_X:       state_next = simp38_pkg::ST_SQ;
            simp38_pkg::ST_SQ:      state_next = simp38_pkg::ST_FSTART;
            simp38_pkg::ST_FSTART:  state_next = simp38_pkg::ST_FDIV_WAIT;
            simp38_pkg::ST_FDIV_WAIT: begin
                if (stat.div_done) state_next = simp38_pkg::ST_ACC;
            end
            simp38_pkg::ST_ACC: begin
                state_next = stat.last_sample ? simp38_pkg::ST_FIN_LO : simp38_pkg::ST_X;
            end
            simp38_pkg::ST_FIN_LO:  state_next = simp38_pkg::ST_FIN_HI;
            simp38_pkg::ST_FIN_HI:  state_next = simp38_pkg::ST_FIN_SUM;
            simp38_pkg::ST_FIN_SUM: state_next = simp38_pkg::ST_ASTART;
            simp38_pkg::ST_ASTART:  state_next = simp38_pkg::ST_AREA_WAIT;
            simp38_pkg::ST_AREA_WAIT: begin
                if (stat.div_done) state_next = simp38_pkg::ST_PUBLISH;
            end
            simp38_pkg::ST_PUBLISH: begin
                if (out_free) state_next = simp38_pkg::ST_IDLE;
            end
            default: state_next = simp38_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op        = simp38_pkg::OP_NONE;
        cmd.div_start = 1'b0;
        cmd.div_sel   = simp38_pkg::DIV_STEP;
        unique case (state_reg)
            simp38_pkg::ST_IDLE: begin
                if (s_tvalid) cmd.op = simp38_pkg::OP_LOAD;
            end
            simp38_pkg::ST_CHECK: begin
                cmd.div_start = !stat.error;
                cmd.div_sel   = simp38_pkg::DIV_STEP;
            end
            simp38_pkg::ST_STEP_WAIT: begin
                if (stat.div_done) cmd.op = simp38_pkg::OP_STEP;
            end
            simp38_pkg::ST_X:  cmd.op = simp38_pkg::OP_X;
            simp38_pkg::ST_SQ: cmd.op = simp38_pkg::OP_SQ;
            simp38_pkg::ST_FSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = simp38_pkg::DIV_SAMPLE;
            end
            simp38_pkg::ST_FDIV_WAIT: cmd.op = simp38_pkg::OP_NONE;
            simp38_pkg::ST_ACC:       cmd.op = simp38_pkg::OP_ACC;
            simp38_pkg::ST_FIN_LO:    cmd.op = simp38_pkg::OP_FIN_LO;
            simp38_pkg::ST_FIN_HI:    cmd.op = simp38_pkg::OP_FIN_HI;
            simp38_pkg::ST_FIN_SUM:   cmd.op = simp38_pkg::OP_FIN_SUM;
            simp38_pkg::ST_ASTART: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = simp38_pkg::DIV_AREA;
            end
            simp38_pkg::ST_AREA_WAIT: cmd.op = simp38_pkg::OP_NONE;
            simp38_pkg::ST_PUBLISH: begin
                if (out_free) cmd.op = simp38_pkg::OP_PUBLISH;
            end
            default: cmd.op = simp38_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.op == simp38_pkg::OP_PUBLISH) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= simp38_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `SIMP38_ASSERT_SAME(a_ctrl_done_in_wait, aclk, aresetn, stat.div_done, (state_reg == simp38_pkg::ST_STEP_WAIT || state_reg == simp38_pkg::ST_FDIV_WAIT || state_reg == simp38_pkg::ST_AREA_WAIT), "divider finished outside a wait state")
    `SIMP38_ASSERT_NEXT(a_ctrl_accept_check, aclk, aresetn, s_tvalid && s_tready, state_reg == simp38_pkg::ST_CHECK, "accepted word not followed by check")
    `SIMP38_ASSERT_SAME(a_ctrl_no_overwrite, aclk, aresetn, cmd.op == simp38_pkg::OP_PUBLISH, !m_valid_reg || m_tready, "result overwrote an untaken word")

endmodule

// File: hdl/simpson_three_eighths_integrator.sv
// A rejected request (upper below lower, or zero intervals) goes straight from
// the check to publish. One request is handled at a time; f(x) for each sample
// is evaluated by the shared divider in its 24-step mode. A result waiting in
// the output register does not block the next request. Synchronous active-low
// reset returns the controller to idle and drops any pending result.
module simpson_three_eighths_integrator (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // lower_limit [23:0], upper_limit [47:24], interval_count [57:48], zero [63:58]
    input  logic [simp38_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // area [31:0]
    output logic [simp38_pkg::M_TDATA_W-1:0]     m_tdata,
    // status [1:0]
    output logic [simp38_pkg::M_TUSER_W-1:0]     m_tuser
);

    simp38_pkg::dp_cmd_t  cmd;
    simp38_pkg::dp_stat_t stat;

    simp38_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    simp38_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
